@@ rtl/core/fractional_anisotropy_macros.svh @@
// Assertion macros shared by the fractional anisotropy RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef FRACTIONAL_ANISOTROPY_MACROS_SVH
`define FRACTIONAL_ANISOTROPY_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FA_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fractional anisotropy check failed");

// Next-cycle implication, disabled during reset.
`define FA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fractional anisotropy check failed");

`endif

@@ rtl/core/fa_pkg.sv @@
// Shared types for the fractional anisotropy pipeline.
// Depends on nothing; used by every stage module and the top level.
`timescale 1ns / 1ps

package fa_pkg;

  // Control that travels with each item down the pipeline.
  typedef struct packed {
    logic valid;
    logic zero;
  } fa_ctl_t;

endpackage

@@ rtl/core/fa_if.sv @@
// Valid/ready channel interfaces for eigenvalue items and result items.
// Depends on nothing.
`timescale 1ns / 1ps

interface fa_in_if #(parameter int EIG_WIDTH = 24);
  logic                        valid;
  logic                        ready;
  logic signed [EIG_WIDTH-1:0] eig_first;
  logic signed [EIG_WIDTH-1:0] eig_second;
  logic signed [EIG_WIDTH-1:0] eig_third;
  modport source (output valid, eig_first, eig_second, eig_third, input ready);
  modport sink (input valid, eig_first, eig_second, eig_third, output ready);
endinterface

interface fa_out_if #(parameter int FRAC_BITS = 16);
  logic                 valid;
  logic                 ready;
  logic [FRAC_BITS:0]   anisotropy;
  logic                 zero_denominator;
  modport source (output valid, anisotropy, zero_denominator, input ready);
  modport sink (input valid, anisotropy, zero_denominator, output ready);
endinterface

@@ rtl/core/fractional_anisotropy.sv @@
// Top level of the fractional anisotropy pipeline.
// Depends on fa_pkg, fa_if, fa_front, fa_div, fa_sqrt and the macros header.
//
// Channel   Dir   Payload
// eig_in    in    eig_first, eig_second, eig_third (signed, EIG_WIDTH bits)
// fa_out    out   anisotropy (FRAC_BITS+1 bits), zero_denominator
//
// One item enters per cycle while the pipeline advances; the stages are
// four front stages, 2*FRAC_BITS+1 divider stages and FRAC_BITS+1 root stages.
// The whole pipeline advances together whenever the result register is empty
// or its item is taken, so a stall freezes every stage in place.
// Reset is synchronous and clears only the control bits (valid and zero).
`timescale 1ns / 1ps
`include "fractional_anisotropy_macros.svh"

module fractional_anisotropy #(
  parameter int EIG_WIDTH = 24,
  parameter int FRAC_BITS = 16
) (
  input logic   clk,
  input logic   rst,
  fa_in_if.sink  eig_in,
  fa_out_if.source fa_out
);

  fa_pkg::fa_ctl_t             front_ctl, div_ctl, root_ctl;
  logic [2*EIG_WIDTH-1:0]      a_val;
  logic [2*EIG_WIDTH:0]        den_val;
  logic [2*FRAC_BITS:0]        quo_val;
  logic [FRAC_BITS:0]          root_val;
  logic                        adv;

  // Global advance: the last stage is the result register.
  assign adv          = !root_ctl.valid || fa_out.ready;
  assign eig_in.ready = adv;

  fa_front #(.EIG_WIDTH(EIG_WIDTH)) u_front (
    .clk, .rst, .en(adv),
    .in_valid(eig_in.valid),
    .e0(eig_in.eig_first), .e1(eig_in.eig_second), .e2(eig_in.eig_third),
    .ctl_out(front_ctl), .a_out(a_val), .den_out(den_val)
  );

  fa_div #(.EIG_WIDTH(EIG_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .rst, .en(adv),
    .ctl_in(front_ctl), .a_in(a_val), .den_in(den_val),
    .ctl_out(div_ctl), .quo_out(quo_val)
  );

  fa_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk, .rst, .en(adv),
    .ctl_in(div_ctl), .val_in(quo_val),
    .ctl_out(root_ctl), .root_out(root_val)
  );

  // All-zero eigenvalues force the result to zero.
  assign fa_out.valid            = root_ctl.valid;
  assign fa_out.zero_denominator = root_ctl.zero;
  assign fa_out.anisotropy       = root_ctl.zero ? '0 : root_val;

  `FA_ASSERT_IMPL(a_zero_forces_0, clk, rst, fa_out.valid && fa_out.zero_denominator, fa_out.anisotropy == '0)
  `FA_ASSERT_IMPL(a_at_most_one, clk, rst, fa_out.valid, fa_out.anisotropy <= ((FRAC_BITS+1)'(1) << FRAC_BITS))
  `FA_ASSERT_NEXT(a_stall_keeps, clk, rst, fa_out.valid && !fa_out.ready, fa_out.valid && $stable(fa_out.anisotropy))

endmodule

@@ rtl/core/fa_front.sv @@
// Front stages: magnitudes, differences, squares and the two sums.
// Depends on fa_pkg.
`timescale 1ns / 1ps

module fa_front #(
  parameter int EIG_WIDTH = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic signed [EIG_WIDTH-1:0] e0,
  input  logic signed [EIG_WIDTH-1:0] e1,
  input  logic signed [EIG_WIDTH-1:0] e2,
  output fa_pkg::fa_ctl_t             ctl_out,
  output logic [2*EIG_WIDTH-1:0]      a_out,
  output logic [2*EIG_WIDTH:0]        den_out
);

  localparam int W  = EIG_WIDTH;
  localparam int SQ = 2 * EIG_WIDTH;

  fa_pkg::fa_ctl_t ctl [1:4];
  logic [W-1:0]    m0, m1, m2;
  logic [W-1:0]    d01, d02, d12, n0, n1, n2;
  logic [SQ-1:0]   s01, s02, s12, q0, q1, q2;
  logic [SQ-1:0]   b_sum;

  // Valid bits advance with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= 4; k++) ctl[k] <= '0;
    end else if (en) begin
      ctl[1] <= '{valid: in_valid, zero: 1'b0};
      ctl[2] <= ctl[1];
      ctl[3] <= ctl[2];
      ctl[4] <= '{valid: ctl[3].valid, zero: (b_sum == '0)};
    end
  end

  assign b_sum = q0 + q1 + q2;

  // Stage 1 takes magnitudes; the most negative value maps to 2^(W-1).
  // Stage 2 forms absolute differences, stage 3 squares, stage 4 sums.
  always_ff @(posedge clk) begin
    if (en) begin
      m0 <= e0[W-1] ? (~e0 + W'(1)) : e0;
      m1 <= e1[W-1] ? (~e1 + W'(1)) : e1;
      m2 <= e2[W-1] ? (~e2 + W'(1)) : e2;
      d01 <= (m0 >= m1) ? (m0 - m1) : (m1 - m0);
      d02 <= (m0 >= m2) ? (m0 - m2) : (m2 - m0);
      d12 <= (m1 >= m2) ? (m1 - m2) : (m2 - m1);
      n0 <= m0;
      n1 <= m1;
      n2 <= m2;
      s01 <= SQ'(d01) * SQ'(d01);
      s02 <= SQ'(d02) * SQ'(d02);
      s12 <= SQ'(d12) * SQ'(d12);
      q0 <= SQ'(n0) * SQ'(n0);
      q1 <= SQ'(n1) * SQ'(n1);
      q2 <= SQ'(n2) * SQ'(n2);
      a_out   <= s01 + s02 + s12;
      den_out <= {b_sum, 1'b0};
    end
  end

  assign ctl_out = ctl[4];

endmodule

@@ rtl/core/fa_div.sv @@
// Restoring divider pipeline: floor(a * 2^(2F) / den), one quotient bit per stage.
// Depends on fa_pkg.
`timescale 1ns / 1ps

module fa_div #(
  parameter int EIG_WIDTH = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  fa_pkg::fa_ctl_t         ctl_in,
  input  logic [2*EIG_WIDTH-1:0]  a_in,
  input  logic [2*EIG_WIDTH:0]    den_in,
  output fa_pkg::fa_ctl_t         ctl_out,
  output logic [2*FRAC_BITS:0]    quo_out
);

  localparam int NSTEP = 2 * FRAC_BITS;
  localparam int RW    = 2 * EIG_WIDTH + 2;
  localparam int DW    = 2 * EIG_WIDTH + 1;
  localparam int QW    = 2 * FRAC_BITS + 1;

  fa_pkg::fa_ctl_t ctl [0:NSTEP];
  logic [RW-1:0]   rem [0:NSTEP];
  logic [DW-1:0]   den [0:NSTEP];
  logic [QW-1:0]   quo [0:NSTEP];
  logic            first_ge;

  // Control bits for every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NSTEP; k++) ctl[k] <= '0;
    end else if (en) begin
      ctl[0] <= ctl_in;
      for (int k = 1; k <= NSTEP; k++) ctl[k] <= ctl[k-1];
    end
  end

  // Integer part: a never exceeds den, so it is a single bit.
  assign first_ge = DW'(a_in) >= den_in;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= first_ge ? RW'(DW'(a_in) - den_in) : RW'(a_in);
      quo[0] <= QW'(first_ge);
      den[0] <= den_in;
    end
  end

  // One fraction bit per stage: shift remainder, compare, subtract.
  for (genvar k = 1; k <= NSTEP; k++) begin : g_step
    logic [RW-1:0] r2;
    logic          ge;
    assign r2 = {rem[k-1][RW-2:0], 1'b0};
    assign ge = r2 >= RW'(den[k-1]);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? (r2 - RW'(den[k-1])) : r2;
        quo[k] <= {quo[k-1][QW-2:0], ge};
        den[k] <= den[k-1];
      end
    end
  end

  assign ctl_out = ctl[NSTEP];
  assign quo_out = quo[NSTEP];

endmodule

@@ rtl/core/fa_sqrt.sv @@
// Digit-by-digit square root pipeline, one result bit per stage.
// Depends on fa_pkg.
`timescale 1ns / 1ps

module fa_sqrt #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  fa_pkg::fa_ctl_t       ctl_in,
  input  logic [2*FRAC_BITS:0]  val_in,
  output fa_pkg::fa_ctl_t       ctl_out,
  output logic [FRAC_BITS:0]    root_out
);

  localparam int NST = FRAC_BITS + 1;
  localparam int SW  = 2 * FRAC_BITS + 2;
  localparam int TW  = FRAC_BITS + 1;

  fa_pkg::fa_ctl_t ctl  [0:NST];
  logic [SW-1:0]   rem  [0:NST];
  logic [TW-1:0]   root [0:NST];

  assign ctl[0]  = ctl_in;
  assign rem[0]  = SW'(val_in);
  assign root[0] = '0;

  // Stage j decides result bit FRAC_BITS-(j-1); rem holds v - root^2.
  for (genvar j = 1; j <= NST; j++) begin : g_bit
    localparam int BI = FRAC_BITS - (j - 1);
    logic [SW-1:0] trial;
    logic          take;
    assign trial = (SW'(root[j-1]) << (BI + 1)) + (SW'(1) << (2 * BI));
    assign take  = rem[j-1] >= trial;
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[j] <= '0;
      end else if (en) begin
        ctl[j] <= ctl[j-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j]  <= take ? (rem[j-1] - trial) : rem[j-1];
        root[j] <= take ? (root[j-1] | (TW'(1) << BI)) : root[j-1];
      end
    end
  end

  assign ctl_out  = ctl[NST];
  assign root_out = root[NST];

endmodule

@@ verif/fa_checker.sv @@
// Checker for the fractional anisotropy block: watches both channels,
// predicts each result from the eigenvalue item and compares in order.
// Depends on fa_if (fa_in_if, fa_out_if).
`timescale 1ns / 1ps

module fa_checker #(
  parameter int EIG_WIDTH = 24,
  parameter int FRAC_BITS = 16
) (
  input logic clk,
  input logic rst,
  fa_in_if    eig_in,
  fa_out_if   fa_out,
  output int  fail_count,
  output int  pending_count
);

  typedef struct packed {
    logic [FRAC_BITS:0] anisotropy;
    logic               zero_denominator;
  } fa_result_t;

  fa_result_t expected_fa_q[$];

  // Magnitude of a signed eigenvalue; the most negative value keeps 2^(W-1).
  function automatic longint unsigned eig_magnitude(logic signed [EIG_WIDTH-1:0] e);
    longint signed s;
    s = e;
    return (s < 0) ? longint'(-s) : longint'(s);
  endfunction

  function automatic longint unsigned abs_diff_sq(longint unsigned x, longint unsigned y);
    longint unsigned d;
    d = (x >= y) ? x - y : y - x;
    return d * d;
  endfunction

  // FA = sqrt(a / 2b) in fixed point, rounded down, computed exactly.
  function automatic fa_result_t predict_fa(logic signed [EIG_WIDTH-1:0] e1,
                                            logic signed [EIG_WIDTH-1:0] e2,
                                            logic signed [EIG_WIDTH-1:0] e3);
    longint unsigned m1, m2, m3, a, b;
    logic [127:0] quot, root, rem, trial;
    fa_result_t r;
    m1 = eig_magnitude(e1);
    m2 = eig_magnitude(e2);
    m3 = eig_magnitude(e3);
    a = abs_diff_sq(m1, m2) + abs_diff_sq(m1, m3) + abs_diff_sq(m2, m3);
    b = m1 * m1 + m2 * m2 + m3 * m3;
    if (b == 0) begin
      r.anisotropy = '0;
      r.zero_denominator = 1'b1;
      return r;
    end
    quot = (128'(a) << (2 * FRAC_BITS)) / (128'(b) * 2);
    // Bitwise integer square root of the scaled quotient.
    root = '0;
    rem = quot;
    for (int i = 63; i >= 0; i--) begin
      trial = root | (128'd1 << i);
      if (trial * trial <= rem) root = trial;
    end
    r.anisotropy = root[FRAC_BITS:0];
    r.zero_denominator = 1'b0;
    return r;
  endfunction

  // Queue a prediction per accepted item; compare each accepted result.
  always @(posedge clk) begin
    fa_result_t got, want;
    if (!rst) begin
      if (eig_in.valid && eig_in.ready)
        expected_fa_q.push_back(predict_fa(eig_in.eig_first, eig_in.eig_second,
                                           eig_in.eig_third));
      if (fa_out.valid && fa_out.ready) begin
        got.anisotropy = fa_out.anisotropy;
        got.zero_denominator = fa_out.zero_denominator;
        if (expected_fa_q.size() == 0) begin
          $error("result with no item pending: anisotropy %0d", got.anisotropy);
          fail_count++;
        end else begin
          want = expected_fa_q.pop_front();
          if (got.anisotropy !== want.anisotropy) begin
            $error("anisotropy: expected %0d, got %0d", want.anisotropy, got.anisotropy);
            fail_count++;
          end
          if (got.zero_denominator !== want.zero_denominator) begin
            $error("zero_denominator: expected %0d, got %0d",
                   want.zero_denominator, got.zero_denominator);
            fail_count++;
          end
        end
      end
    end
    pending_count <= expected_fa_q.size();
  end

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

endmodule

@@ verif/tb_top.sv @@
// Testbench top for fractional_anisotropy: drives eigenvalue items with
// directed and random values under several idle mixes; fa_checker judges.
// Depends on fa_if, fa_checker and the fractional_anisotropy RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int EIG_WIDTH = 24;
  localparam int FRAC_BITS = 16;
  localparam int LATENCY = 3 * FRAC_BITS + 6;
  localparam logic signed [EIG_WIDTH-1:0] EIG_MAX = {1'b0, {(EIG_WIDTH-1){1'b1}}};
  localparam logic signed [EIG_WIDTH-1:0] EIG_MIN = {1'b1, {(EIG_WIDTH-1){1'b0}}};

  logic clk;
  logic rst;
  int   fail_count;
  int   pending_count;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_cycles;

  fa_in_if  #(.EIG_WIDTH(EIG_WIDTH)) eig_in ();
  fa_out_if #(.FRAC_BITS(FRAC_BITS)) fa_out ();

  fractional_anisotropy #(.EIG_WIDTH(EIG_WIDTH), .FRAC_BITS(FRAC_BITS)) dut (
    .clk    (clk),
    .rst    (rst),
    .eig_in (eig_in.sink),
    .fa_out (fa_out.source)
  );

  fa_checker #(.EIG_WIDTH(EIG_WIDTH), .FRAC_BITS(FRAC_BITS)) checker_inst (
    .clk           (clk),
    .rst           (rst),
    .eig_in        (eig_in),
    .fa_out        (fa_out),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: random stalls, or a long hold-off while hold_cycles is set.
  always @(posedge clk) begin
    if (rst) begin
      fa_out.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      fa_out.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      fa_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Random eigenvalue, biased toward small and extreme magnitudes.
  function automatic logic signed [EIG_WIDTH-1:0] rand_eig();
    case ($urandom_range(5))
      0: return EIG_WIDTH'($signed($urandom_range(32)) - 16);
      1: return $urandom_range(1) ? EIG_MAX : EIG_MIN;
      2: return EIG_WIDTH'($signed($urandom_range(2000)) - 1000);
      default: return EIG_WIDTH'($urandom);
    endcase
  endfunction

  // Offer one item and hold it until accepted, idling at random first.
  task automatic send_eig(logic signed [EIG_WIDTH-1:0] e1,
                          logic signed [EIG_WIDTH-1:0] e2,
                          logic signed [EIG_WIDTH-1:0] e3);
    while ($urandom_range(99) < send_idle_pct) begin
      eig_in.valid <= 1'b0;
      @(posedge clk);
    end
    eig_in.valid <= 1'b1;
    eig_in.eig_first <= e1;
    eig_in.eig_second <= e2;
    eig_in.eig_third <= e3;
    @(posedge clk);
    while (!eig_in.ready) @(posedge clk);
  endtask

  task automatic drain();
    eig_in.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0 || hold_cycles != 0) @(posedge clk);
  endtask

  task automatic send_random(int count);
    logic signed [EIG_WIDTH-1:0] e;
    for (int i = 0; i < count; i++) begin
      // Some items are isotropic or share a magnitude with opposite signs.
      e = rand_eig();
      case ($urandom_range(7))
        0: send_eig(e, e, e);
        1: send_eig(e, -e, e);
        2: send_eig(e, '0, '0);
        default: send_eig(rand_eig(), rand_eig(), rand_eig());
      endcase
    end
  endtask

  initial begin
    rst = 1'b1;
    eig_in.valid = 1'b0;
    eig_in.eig_first = '0;
    eig_in.eig_second = '0;
    eig_in.eig_third = '0;
    fa_out.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: all zero, extremes, most negative input, isotropic, one-hot.
    send_eig('0, '0, '0);
    send_eig(EIG_MAX, EIG_MAX, EIG_MAX);
    send_eig(EIG_MIN, EIG_MIN, EIG_MIN);
    send_eig(EIG_MIN, EIG_MAX, '0);
    send_eig(EIG_MIN, '0, '0);
    send_eig('0, EIG_MIN, '0);
    send_eig('0, '0, EIG_MIN);
    send_eig(EIG_MAX, '0, '0);
    send_eig(EIG_MAX, EIG_MIN, EIG_MAX);
    send_eig(EIG_WIDTH'(-1), EIG_WIDTH'(-1), EIG_WIDTH'(-1));
    send_eig(EIG_WIDTH'(1), EIG_WIDTH'(-1), EIG_WIDTH'(1));
    send_eig(EIG_WIDTH'(1), '0, '0);
    send_eig(EIG_WIDTH'(-1), '0, '0);
    send_eig(EIG_WIDTH'(3), EIG_WIDTH'(2), EIG_WIDTH'(1));
    send_eig(EIG_WIDTH'(-3), EIG_WIDTH'(2), EIG_WIDTH'(-1));
    send_eig(EIG_MAX, EIG_MAX, '0);
    send_eig(EIG_MIN, EIG_MIN, EIG_WIDTH'(1));
    send_eig(24'h555555, 24'sh2AAAAA, 24'hAAAAAA);
    send_eig(24'h7FFFFE, EIG_WIDTH'(1), '0);
    send_eig('0, '0, '0);
    drain();

    // Random phases over the idle mixes.
    send_random(200);
    send_idle_pct = 46;
    send_random(150);
    send_idle_pct = 0;
    recv_stall_pct = 46;
    send_random(150);
    send_idle_pct = 35;
    recv_stall_pct = 35;
    send_random(150);
    // Sender pauses until every result is back.
    drain();

    // Long receiver hold-off while the sender keeps offering items.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 3 * LATENCY;
    send_random(120);
    recv_stall_pct = 20;
    send_random(60);
    drain();

    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #4ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/fa_pkg.sv
rtl/core/fa_if.sv
rtl/core/fa_front.sv
rtl/core/fa_div.sv
rtl/core/fa_sqrt.sv
rtl/core/fractional_anisotropy.sv
verif/fa_checker.sv
verif/tb_top.sv
